// ===== sv/sha1md_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 digest engine.
// No dependencies; imported by every module of the block.
package sha1md_pkg;

    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 32;
    localparam int NUM_H           = 5;
    localparam int SCHED_DEPTH     = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int IDX_W           = 3;
    localparam int ROUND_W         = 7;
    localparam int BLOCK_CNT_W     = 6;
    localparam int LEN_BYTES_W     = 61;

    localparam logic [IDX_W-1:0]       LAST_WORD_IDX = 3'd4;
    localparam logic [ROUND_W-1:0]     LAST_ROUND    = 7'd79;
    localparam logic [BLOCK_CNT_W-1:0] LAST_BYTE_POS = 6'd63;
    localparam logic [BLOCK_CNT_W-1:0] LEN_FIELD_POS = 6'd56;
    localparam logic [BYTE_W-1:0]      PAD_MARK      = 8'h80;
    localparam logic [BYTE_W-1:0]      PAD_ZERO      = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              eom;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

    typedef enum logic [2:0] {
        ST_FEED,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } back_state_t;

    function automatic logic [WORD_W-1:0] h_init(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            default: val = 32'hC3D2E1F0;
        endcase
        return val;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
        logic [WORD_W-1:0] val;
        if (rnd < 7'd20) begin
            val = 32'h5A827999;
        end else if (rnd < 7'd40) begin
            val = 32'h6ED9EBA1;
        end else if (rnd < 7'd60) begin
            val = 32'h8F1BBCDC;
        end else begin
            val = 32'hCA62C1D6;
        end
        return val;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] rnd,
                                                  input logic [WORD_W-1:0]  b,
                                                  input logic [WORD_W-1:0]  c,
                                                  input logic [WORD_W-1:0]  d);
        logic [WORD_W-1:0] val;
        if (rnd < 7'd20) begin
            val = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            val = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            val = (b & c) | (b & d) | (c & d);
        end else begin
            val = b ^ c ^ d;
        end
        return val;
    endfunction

endpackage

// ===== sv/sha1md_front.sv =====
// Input stage: accepts stream requests, drops empty ones, holds one command.
// Depends on sha1md_pkg; feeds sha1md_fifo.
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,
    input  logic              s_axis_tuser,
    input  logic              s_axis_tlast,
    input  logic              q_full,
    output cmd_req_t          push
);

    logic valid_reg, valid_next;
    cmd_t cmd_reg;
    logic take;
    logic keep;

    assign s_axis_tready = !valid_reg || !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign keep          = s_axis_tuser || s_axis_tlast;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && !q_full) begin
            valid_next = 1'b0;
        end
        if (take && keep) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && keep) begin
            cmd_reg.data     <= s_axis_tdata;
            cmd_reg.has_byte <= s_axis_tuser;
            cmd_reg.eom      <= s_axis_tlast;
        end
    end

    assign push.valid = valid_reg && !q_full;
    assign push.cmd   = cmd_reg;

endmodule

// ===== sv/sha1md_fifo.sv =====
// Command queue between the input stage and the hash back end.
// Depends on sha1md_pkg.
module sha1md_fifo
    import sha1md_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cmd_req_t push,
    output logic     full,
    output logic     head_valid,
    output cmd_t     head,
    input  logic     pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// ===== sv/sha1md_back.sv =====
// Hash back end: packs bytes into blocks, pads, runs the 80 rounds, emits the digest.
// Depends on sha1md_pkg; takes commands from sha1md_fifo.
module sha1md_back
    import sha1md_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,
    output logic [IDX_W-1:0]  m_axis_tuser,
    output logic              m_axis_tlast
);

    back_state_t state_reg, state_next;
    back_state_t ret_reg, ret_next;
    back_state_t after_put;

    logic [BLOCK_CNT_W-1:0] cnt_reg, cnt_after;
    logic [23:0]            acc_reg;
    logic [WORD_W-1:0]      wsh_reg [SCHED_DEPTH];
    logic [WORD_W-1:0]      a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0]      h_reg [NUM_H];
    logic [LEN_BYTES_W-1:0] len_reg;
    logic [ROUND_W-1:0]     rnd_reg;
    logic [IDX_W-1:0]       lidx_reg;
    logic [IDX_W-1:0]       oidx_reg;

    logic              put_en;
    logic [BYTE_W-1:0] put_val;
    logic              put_wrap;
    logic              word_done;
    logic [WORD_W-1:0] new_word;
    logic [63:0]       bit_len;
    logic [63:0]       len_shift;
    logic [WORD_W-1:0] sched_word;
    logic [WORD_W-1:0] t_word;
    logic              out_take;

    assign bit_len    = {len_reg, 3'b000};
    assign len_shift  = bit_len >> {~lidx_reg, 3'b000};
    assign cnt_after  = cnt_reg + 1'b1;
    assign put_wrap   = put_en && (cnt_reg == LAST_BYTE_POS);
    assign word_done  = put_en && (cnt_reg[1:0] == 2'b11);
    assign new_word   = {acc_reg, put_val};
    assign sched_word = {wsh_reg[13] ^ wsh_reg[8] ^ wsh_reg[2] ^ wsh_reg[0]} << 1
                      | {wsh_reg[13] ^ wsh_reg[8] ^ wsh_reg[2] ^ wsh_reg[0]} >> 31;
    assign t_word     = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                      + e_reg + round_k(rnd_reg) + wsh_reg[0];
    assign out_take   = m_axis_tvalid && m_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        after_put  = state_reg;
        case (state_reg)
            ST_FEED: begin
                if (q_valid) begin
                    after_put = q_cmd.eom ? ST_MARK : ST_FEED;
                    if (put_wrap) begin
                        state_next = ST_ROUND;
                        ret_next   = after_put;
                    end else begin
                        state_next = after_put;
                    end
                end
            end
            ST_MARK, ST_ZERO: begin
                after_put = (cnt_after == LEN_FIELD_POS) ? ST_LEN : ST_ZERO;
                if (put_wrap) begin
                    state_next = ST_ROUND;
                    ret_next   = after_put;
                end else begin
                    state_next = after_put;
                end
            end
            ST_LEN: begin
                if (put_wrap) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_OUT;
                end
            end
            ST_ROUND: begin
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                state_next = ret_reg;
            end
            ST_OUT: begin
                if (m_axis_tready && (oidx_reg == LAST_WORD_IDX)) begin
                    state_next = ST_FEED;
                end
            end
            default: begin
                state_next = ST_FEED;
            end
        endcase
    end

    // outputs and byte source
    always_comb begin
        q_pop         = 1'b0;
        put_en        = 1'b0;
        put_val       = PAD_ZERO;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_FEED: begin
                q_pop   = q_valid;
                put_en  = q_valid && q_cmd.has_byte;
                put_val = q_cmd.data;
            end
            ST_MARK: begin
                put_en  = 1'b1;
                put_val = PAD_MARK;
            end
            ST_ZERO: begin
                put_en  = 1'b1;
                put_val = PAD_ZERO;
            end
            ST_LEN: begin
                put_en  = 1'b1;
                put_val = len_shift[7:0];
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = h_reg[oidx_reg];
    assign m_axis_tuser = oidx_reg;
    assign m_axis_tlast = oidx_reg == LAST_WORD_IDX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FEED;
            ret_reg   <= ST_FEED;
            cnt_reg   <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            lidx_reg  <= '0;
            oidx_reg  <= '0;
            for (int i = 0; i < NUM_H; i++) begin
                h_reg[i] <= h_init(IDX_W'(i));
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (put_en) begin
                cnt_reg <= cnt_after;
            end
            if (state_reg == ST_FEED && q_valid && q_cmd.has_byte) begin
                len_reg <= len_reg + 1'b1;
            end
            if (state_reg == ST_LEN && put_en) begin
                lidx_reg <= lidx_reg + 1'b1;
            end
            if (state_reg == ST_ROUND) begin
                rnd_reg <= (rnd_reg == LAST_ROUND) ? '0 : rnd_reg + 1'b1;
            end
            if (state_reg == ST_ADD) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (out_take) begin
                if (oidx_reg == LAST_WORD_IDX) begin
                    oidx_reg <= '0;
                    len_reg  <= '0;
                    for (int i = 0; i < NUM_H; i++) begin
                        h_reg[i] <= h_init(IDX_W'(i));
                    end
                end else begin
                    oidx_reg <= oidx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (put_en) begin
            acc_reg <= {acc_reg[15:0], put_val};
        end
        if (word_done || state_reg == ST_ROUND) begin
            for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
                wsh_reg[i] <= wsh_reg[i+1];
            end
            wsh_reg[SCHED_DEPTH-1] <= word_done ? new_word : sched_word;
        end
        if (put_wrap) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (state_reg == ST_ROUND) begin
            a_reg <= t_word;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_OUT) |-> $past(state_reg) == ST_ADD)
        else $error("digest shown without a finished block");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LEN |-> cnt_reg[5:3] == 3'b111)
        else $error("length bytes outside the last eight block positions");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND && $past(state_reg) != ST_ROUND |-> rnd_reg == '0)
        else $error("round sequence started mid-count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_take && m_axis_tlast |=> state_reg == ST_FEED && cnt_reg == '0 && len_reg == '0)
        else $error("engine not cleared after the final digest word");

endmodule

// ===== sv/sha1_message_digest.sv =====
// SHA-1 digest engine: message bytes stream in on s_axis, each message's
// 160-bit digest leaves on m_axis as five 32-bit words, h0 first (tuser holds
// the word index, tlast marks h4). An input request with tuser low carries no
// byte; tlast ends the message, after any byte in the same request. The back
// end packs the bytes one at a time, and every full 64-byte block then holds
// it while the single round unit runs 80 rounds and adds into the chaining
// value. End of message adds padding bytes up to the next block end, one or
// two padded blocks, then the five digest words. Input requests keep landing
// in the command queue while the rounds run or the digest waits, until
// QUEUE_DEPTH plus one are held.
// Depends on sha1md_pkg, sha1md_front, sha1md_fifo and sha1md_back.
module sha1_message_digest
    import sha1md_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tuser,   // [0] has_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,   // [31:0] digest_word
    output logic [IDX_W-1:0]  m_axis_tuser,   // [2:0] word_index
    output logic              m_axis_tlast
);

    cmd_req_t push;
    logic     q_full;
    logic     q_valid;
    cmd_t     q_cmd;
    logic     q_pop;

    sha1md_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .push          (push)
    );

    sha1md_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_cmd),
        .pop        (q_pop)
    );

    sha1md_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
